[hw/rtl/aes_pkg.sv]
// ----------------------------------------------------------------------------
// AES package
// Shared types, substitution tables and round functions of the AES core.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int unsigned MAX_ROUNDS_DEF = 14;

	// Byte k of a block sits at index k, byte 0 in the most significant place.
	typedef logic [0:15][7:0] aes_state_t;

	typedef enum logic [2:0] {
		REG_KEY_WORD_0  = 3'd0,
		REG_KEY_WORD_1  = 3'd1,
		REG_KEY_WORD_2  = 3'd2,
		REG_KEY_WORD_3  = 3'd3,
		REG_KEY_LENGTH  = 3'd4,
		REG_CIPHER_MODE = 3'd5,
		REG_IV_HIGH     = 3'd6,
		REG_IV_LOW      = 3'd7
	} cfg_reg_t;

	localparam logic [7:0] RCON_FIRST = 8'h01;
	localparam logic [7:0] GF_POLY    = 8'h1b;

	localparam logic [0:255][7:0] FWD_SBOX = {
		128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
	};

	localparam logic [0:255][7:0] REV_SBOX = {
		128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
		128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
		128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
		128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
		128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
		128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
		128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
		128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
	endfunction

	// Multiply by a constant of up to four bits.
	function automatic logic [7:0] gf_mul_c(input logic [7:0] a, input logic [3:0] c);
		logic [7:0] a2, a4, a8;
		a2 = xtime(a);
		a4 = xtime(a2);
		a8 = xtime(a4);
		gf_mul_c = (c[0] ? a : 8'h00) ^ (c[1] ? a2 : 8'h00) ^
			(c[2] ? a4 : 8'h00) ^ (c[3] ? a8 : 8'h00);
	endfunction

	function automatic aes_state_t sub_shift_fwd(input aes_state_t s);
		aes_state_t o;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				o[r + 4 * c] = FWD_SBOX[s[r + 4 * ((c + r) & 3)]];
			end
		end
		sub_shift_fwd = o;
	endfunction

	function automatic aes_state_t sub_shift_inv(input aes_state_t s);
		aes_state_t o;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				o[r + 4 * ((c + r) & 3)] = REV_SBOX[s[r + 4 * c]];
			end
		end
		sub_shift_inv = o;
	endfunction

	// Column mix with coefficient row m; row r uses m[(k - r) mod 4] on byte k.
	function automatic aes_state_t mix_cols(input aes_state_t s, input logic inv);
		aes_state_t o;
		logic [3:0] m [4];
		logic [7:0] v;
		if (inv) begin
			m[0] = 4'd14; m[1] = 4'd11; m[2] = 4'd13; m[3] = 4'd9;
		end else begin
			m[0] = 4'd2;  m[1] = 4'd3;  m[2] = 4'd1;  m[3] = 4'd1;
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				v = 8'h00;
				for (int k = 0; k < 4; k++) begin
					v = v ^ gf_mul_c(s[4 * c + k], m[(k - r) & 3]);
				end
				o[4 * c + r] = v;
			end
		end
		mix_cols = o;
	endfunction

endpackage

[hw/rtl/aes_block_cipher_ecb_cbc.sv]
// ----------------------------------------------------------------------------
// AES block cipher, ECB and CBC
// Iterative AES-128/192/256 core with on-chip key schedule and CBC chaining.
// ----------------------------------------------------------------------------
// Usage:
//   Configure key words, key length, mode and IV through the write port while
//   the core is idle. Writing a key word or the key length marks the round
//   keys stale; the next transaction rebuilds them first.
//   The input channel takes one 128-bit block per transaction. start_chain
//   reloads the CBC chaining value from the IV before the block is used.
//   in_stall stays high while a block is in flight.
// Round unit and key expansion:
//   One shared round unit runs one round per cycle. A block goes from
//   acceptance through the load state, the round state once per round
//   (Nr = 10, 12 or 14) and the finish state into the result register; no
//   new block enters until the last leaves finish. Stale keys first get key
//   expansion, one 32-bit schedule word per cycle via a four-byte S-box lane.
// Output:
//   The result is held in an output register; the core goes back to idle
//   and accepts the next block while the result waits. If the receiver
//   stalls, the next finished block holds in the core until the register
//   frees up. Reset clears configuration, chaining value and key status.
// ----------------------------------------------------------------------------
module aes_block_cipher_ecb_cbc
	import aes_pkg::*;
#(
	parameter int unsigned MAX_ROUNDS = MAX_ROUNDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	input  logic        start_chain,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);

	localparam int unsigned RK_DEPTH = MAX_ROUNDS + 1;
	localparam int unsigned RK_AW    = $clog2(RK_DEPTH);
	localparam int unsigned WI_W     = RK_AW + 2;
	localparam int unsigned MAX_SEL  = (MAX_ROUNDS - 10) / 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_LOAD,
		ST_ROUND,
		ST_FINISH
	} state_t;

	state_t state_q;

	// configuration
	logic [63:0] kw0_q, kw1_q, kw2_q, kw3_q, iv_hi_q, iv_lo_q;
	logic [1:0]  key_len_q, mode_q;
	logic        keys_ready_q;

	// block datapath
	aes_state_t  data_q, blk_q, chain_q;
	logic [RK_AW-1:0] ri_q;
	logic        out_valid_q;
	logic [127:0] result_q;

	// key schedule
	logic [3:0][31:0] rk_q [RK_DEPTH];
	logic [7:0][31:0] win_q;
	logic [WI_W-1:0]  wi_q;
	logic [2:0]       kmod_q;
	logic [7:0]       rc_q;

	logic decrypt, cbc;
	assign decrypt = mode_q[0];
	assign cbc     = mode_q[1];

	// Key size select: code 3 acts as 256-bit, clip to what MAX_ROUNDS allows.
	logic [1:0] ks_raw, ks;
	logic [2:0] nk_m1;
	logic [RK_AW-1:0] nr;
	logic [WI_W-1:0]  wi_last;
	always_comb begin
		ks_raw = (key_len_q == 2'd3) ? 2'd2 : key_len_q;
		ks     = (ks_raw > 2'(MAX_SEL)) ? 2'(MAX_SEL) : ks_raw;
		nk_m1  = {ks, 1'b0} + 3'd3;
		nr     = RK_AW'(4'd10 + {1'b0, ks, 1'b0});
		wi_last = {nr, 2'b11};
	end

	// Key expansion word
	logic [7:0][31:0] key_words;
	logic        is_key_word;
	logic [31:0] t_word, new_word;
	assign key_words   = {kw0_q, kw1_q, kw2_q, kw3_q};
	assign is_key_word = (wi_q <= WI_W'(nk_m1));
	always_comb begin
		t_word = win_q[0];
		if (kmod_q == 3'd0) begin
			t_word = {FWD_SBOX[win_q[0][23:16]] ^ rc_q, FWD_SBOX[win_q[0][15:8]],
				FWD_SBOX[win_q[0][7:0]], FWD_SBOX[win_q[0][31:24]]};
		end else if (nk_m1 == 3'd7 && kmod_q == 3'd4) begin
			t_word = {FWD_SBOX[win_q[0][31:24]], FWD_SBOX[win_q[0][23:16]],
				FWD_SBOX[win_q[0][15:8]], FWD_SBOX[win_q[0][7:0]]};
		end
		new_word = is_key_word ? key_words[3'd7 - wi_q[2:0]] : (win_q[nk_m1] ^ t_word);
	end

	// Shared round unit
	aes_state_t rkey, enc_ss, dec_add, round_out;
	logic       last_round;
	always_comb begin
		rkey       = aes_state_t'(rk_q[ri_q]);
		last_round = decrypt ? (ri_q == '0) : (ri_q == nr);
		enc_ss     = sub_shift_fwd(data_q);
		dec_add    = sub_shift_inv(data_q) ^ rkey;
		if (decrypt) begin
			round_out = last_round ? dec_add : mix_cols(dec_add, 1'b1);
		end else begin
			round_out = (last_round ? enc_ss : mix_cols(enc_ss, 1'b0)) ^ rkey;
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign result_high = result_q[127:64];
	assign result_low  = result_q[63:0];

	// Round key store: one schedule word per cycle, no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_EXPAND) begin
			rk_q[wi_q[WI_W-1:2]][2'd3 - wi_q[1:0]] <= new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			kw0_q        <= '0;
			kw1_q        <= '0;
			kw2_q        <= '0;
			kw3_q        <= '0;
			key_len_q    <= '0;
			mode_q       <= '0;
			iv_hi_q      <= '0;
			iv_lo_q      <= '0;
			keys_ready_q <= 1'b0;
			chain_q      <= '0;
			out_valid_q  <= 1'b0;
			data_q       <= '0;
			blk_q        <= '0;
			ri_q         <= '0;
			result_q     <= '0;
			win_q        <= '0;
			wi_q         <= '0;
			kmod_q       <= '0;
			rc_q         <= RCON_FIRST;
		end else begin
			// config writes must arrive only while idle; the core does not enforce this
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_KEY_WORD_0: begin kw0_q <= cfg_data; keys_ready_q <= 1'b0; end
					REG_KEY_WORD_1: begin kw1_q <= cfg_data; keys_ready_q <= 1'b0; end
					REG_KEY_WORD_2: begin kw2_q <= cfg_data; keys_ready_q <= 1'b0; end
					REG_KEY_WORD_3: begin kw3_q <= cfg_data; keys_ready_q <= 1'b0; end
					REG_KEY_LENGTH: begin
						key_len_q    <= cfg_data[1:0];
						keys_ready_q <= 1'b0;
					end
					REG_CIPHER_MODE: mode_q  <= cfg_data[1:0];
					REG_IV_HIGH:     iv_hi_q <= cfg_data;
					REG_IV_LOW:      iv_lo_q <= cfg_data;
				endcase
			end

			// drop the result once the transaction completes; in the finish
			// state the next block refills the register in the same cycle
			if (out_valid_q && !out_stall && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						blk_q  <= {block_high, block_low};
						ri_q   <= decrypt ? nr : '0;
						if (start_chain) begin
							chain_q <= {iv_hi_q, iv_lo_q};
						end
						wi_q   <= '0;
						kmod_q <= 3'd0;
						rc_q   <= RCON_FIRST;
						state_q <= keys_ready_q ? ST_LOAD : ST_EXPAND;
					end
				end
				ST_EXPAND: begin
					win_q  <= {win_q[6:0], new_word};
					kmod_q <= (kmod_q == nk_m1) ? 3'd0 : kmod_q + 3'd1;
					if (!is_key_word && kmod_q == 3'd0) begin
						rc_q <= xtime(rc_q);
					end
					wi_q <= wi_q + 1'b1;
					if (wi_q == wi_last) begin
						keys_ready_q <= 1'b1;
						state_q      <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					// initial key add, with chain folded in for CBC encrypt
					data_q  <= blk_q ^ ((cbc && !decrypt) ? chain_q : '0) ^ rkey;
					ri_q    <= decrypt ? ri_q - 1'b1 : ri_q + 1'b1;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					data_q <= round_out;
					if (last_round) begin
						state_q <= ST_FINISH;
					end else begin
						ri_q <= decrypt ? ri_q - 1'b1 : ri_q + 1'b1;
					end
				end
				ST_FINISH: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						if (cbc && decrypt) begin
							result_q <= data_q ^ chain_q;
							chain_q  <= blk_q;
						end else begin
							result_q <= data_q;
							if (cbc) begin
								chain_q <= data_q;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[tb/aes_checker.sv]
// ----------------------------------------------------------------------------
// AES ECB/CBC checker
// Tracks the configuration writes, predicts each result block from the
// accepted input blocks and compares the results in order.
// ----------------------------------------------------------------------------
module aes_checker
	import aes_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	input  logic        start_chain,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] result_high,
	input  logic [63:0] result_low,
	output int unsigned fail_count,
	output int unsigned pending
);

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
	} cipher_blk_t;

	logic [7:0] fwd_tab [256];
	logic [7:0] inv_tab [256];

	logic [63:0] key_q [4];
	logic [1:0]  klen_q;
	logic [1:0]  mode_q;
	logic [63:0] iv_hi_q, iv_lo_q;
	aes_state_t  chain_q;
	logic        keys_ok_q;
	aes_state_t  rkeys [15];
	int unsigned nrounds;

	cipher_blk_t expected_blocks [$];
	int unsigned block_no;

	assign pending = expected_blocks.size();

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int k = 0; k < 8; k++) begin
			if (b[0]) p = p ^ a;
			a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
			b = b >> 1;
		end
		return p;
	endfunction

	// Build the substitution tables from the field inverse and the affine map.
	initial begin
		logic [15:0] j;
		logic [7:0]  inv;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h00;
			for (int y = 1; y < 256 && x != 0; y++) begin
				if (gmul(x[7:0], y[7:0]) == 8'h01) begin
					inv = y[7:0];
					break;
				end
			end
			j = {8'h00, inv};
			j = j ^ (j << 1) ^ (j << 2) ^ (j << 3) ^ (j << 4);
			j = (j ^ (j >> 8) ^ 16'd99) & 16'hff;
			fwd_tab[x] = j[7:0];
			inv_tab[j[7:0]] = x[7:0];
		end
	end

	function automatic aes_state_t to_state(input logic [63:0] hi, input logic [63:0] lo);
		return aes_state_t'({hi, lo});
	endfunction

	function automatic void build_schedule();
		logic [7:0]  w [60][4];
		logic [7:0]  t [4];
		logic [7:0]  kb [32];
		logic [7:0]  rc, f;
		int unsigned nk, total;
		// Length code 3 runs as a 256-bit key.
		nk = (klen_q == 2'd0) ? 4 : (klen_q == 2'd1) ? 6 : 8;
		nrounds = nk + 6;
		total = 4 * (nrounds + 1);
		for (int i = 0; i < 32; i++) kb[i] = key_q[i / 8][63 - 8 * (i % 8) -: 8];
		for (int i = 0; i < nk; i++)
			for (int k = 0; k < 4; k++) w[i][k] = kb[4 * i + k];
		rc = 8'h01;
		for (int i = nk; i < total; i++) begin
			t = w[i - 1];
			if (i % nk == 0) begin
				f = t[0];
				t[0] = fwd_tab[t[1]] ^ rc;
				t[1] = fwd_tab[t[2]];
				t[2] = fwd_tab[t[3]];
				t[3] = fwd_tab[f];
				rc = gmul(rc, 8'h02);
			end else if (nk > 6 && i % nk == 4) begin
				for (int k = 0; k < 4; k++) t[k] = fwd_tab[t[k]];
			end
			for (int k = 0; k < 4; k++) w[i][k] = w[i - nk][k] ^ t[k];
		end
		for (int i = 0; i <= nrounds; i++)
			for (int k = 0; k < 16; k++) rkeys[i][k] = w[4 * i + k / 4][k % 4];
		keys_ok_q = 1'b1;
	endfunction

	function automatic aes_state_t subshift(input aes_state_t s, input logic inverse);
		aes_state_t o;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				if (inverse) o[r + 4 * ((c + r) & 3)] = inv_tab[s[r + 4 * c]];
				else o[r + 4 * c] = fwd_tab[s[r + 4 * ((c + r) & 3)]];
			end
		return o;
	endfunction

	function automatic aes_state_t mixcol(input aes_state_t s, input logic inverse);
		aes_state_t o;
		logic [7:0] m [4];
		logic [7:0] v;
		if (inverse) m = '{8'd14, 8'd11, 8'd13, 8'd9};
		else m = '{8'd2, 8'd3, 8'd1, 8'd1};
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				v = 8'h00;
				for (int k = 0; k < 4; k++) v = v ^ gmul(m[(k - r) & 3], s[4 * c + k]);
				o[4 * c + r] = v;
			end
		return o;
	endfunction

	function automatic cipher_blk_t predict_block(input logic [63:0] hi,
			input logic [63:0] lo, input logic sc);
		aes_state_t blk, s;
		if (!keys_ok_q) build_schedule();
		if (sc) chain_q = to_state(iv_hi_q, iv_lo_q);
		blk = to_state(hi, lo);
		s = blk;
		if (!mode_q[0]) begin
			if (mode_q[1]) s = s ^ chain_q;
			s = s ^ rkeys[0];
			for (int r = 1; r < nrounds; r++) s = mixcol(subshift(s, 1'b0), 1'b0) ^ rkeys[r];
			s = subshift(s, 1'b0) ^ rkeys[nrounds];
			if (mode_q[1]) chain_q = s;
		end else begin
			s = s ^ rkeys[nrounds];
			for (int r = nrounds - 1; r > 0; r--) s = mixcol(subshift(s, 1'b1) ^ rkeys[r], 1'b1);
			s = subshift(s, 1'b1) ^ rkeys[0];
			if (mode_q[1]) begin
				s = s ^ chain_q;
				chain_q = blk;
			end
		end
		return cipher_blk_t'(s);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch block %0d %s: got %h expected %h", block_no, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		cipher_blk_t e;
		if (!arst_n) begin
			key_q = '{default: 64'h0};
			klen_q = 2'd0;
			mode_q = 2'd0;
			iv_hi_q = 64'h0;
			iv_lo_q = 64'h0;
			chain_q = '0;
			keys_ok_q = 1'b0;
			nrounds = 10;
			fail_count = 0;
			block_no = 0;
			expected_blocks.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3: begin
						key_q[cfg_index[1:0]] = cfg_data;
						keys_ok_q = 1'b0;
					end
					REG_KEY_LENGTH: begin
						klen_q = cfg_data[1:0];
						keys_ok_q = 1'b0;
					end
					REG_CIPHER_MODE: mode_q = cfg_data[1:0];
					REG_IV_HIGH: iv_hi_q = cfg_data;
					REG_IV_LOW: iv_lo_q = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_blocks.push_back(predict_block(block_high, block_low, start_chain));
			if (out_valid && !out_stall) begin
				if (expected_blocks.size() == 0) begin
					report_mismatch("unexpected", result_high, 64'h0);
				end else begin
					e = expected_blocks.pop_front();
					if (result_high !== e.hi) report_mismatch("high", result_high, e.hi);
					if (result_low !== e.lo) report_mismatch("low", result_low, e.lo);
				end
				block_no++;
			end
		end
	end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// AES ECB/CBC block cipher testbench
// Runs the core through every key length and cipher mode with extreme and
// random keys, directed and random blocks, bursty input and a stalling
// receiver; the checker predicts and compares every result block.
// ----------------------------------------------------------------------------
module testbench;
	import aes_pkg::*;

	localparam int unsigned NUM_PHASES  = 16;
	localparam int unsigned RAND_BLOCKS = 45;
	// Worst stretch without a transaction: key expansion plus a 14-round
	// block, a long receiver stall and a sender gap, with generous margin.
	localparam int unsigned IDLE_LIMIT  = 3000;
	localparam int unsigned DRAIN_WAIT  = 80;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] block_high;
	logic [63:0] block_low;
	logic        start_chain;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] result_high;
	logic [63:0] result_low;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned burst_left;
	int unsigned idle_cycles;
	int unsigned stall_style;
	int unsigned sent_blocks;
	int unsigned chain_starts;

	aes_block_cipher_ecb_cbc u_top (.*);

	aes_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: switch at random among no stall, light and heavy stalling.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_style <= 0;
		end else begin
			if ($urandom_range(0, 63) == 0) stall_style <= $urandom_range(0, 2);
			case (stall_style)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Watchdog: end the run if no transaction moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// Send one block; hold the payload until the core takes the transaction.
	task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input logic sc);
		logic taken;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		block_high <= hi;
		block_low <= lo;
		start_chain <= sc;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		burst_left--;
		sent_blocks++;
		if (sc) chain_starts++;
	endtask

	// Wait until every expected block has come back, then let the core settle.
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		logic [63:0] key_fill;
		logic        sc;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		block_high = '0;
		block_low = '0;
		start_chain = 1'b0;
		idle_cycles = 0;
		burst_left = 0;
		sent_blocks = 0;
		chain_starts = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sweep every key length code (3 included) against every cipher mode.
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_reg(REG_KEY_LENGTH, 64'(p % 4));
			write_reg(REG_CIPHER_MODE, 64'(p / 4));
			for (int w = 0; w < 4; w++) begin
				if (p == 0) key_fill = 64'h0;
				else if (p == 5) key_fill = '1;
				else key_fill = {$urandom, $urandom};
				write_reg(cfg_reg_t'(w), key_fill);
			end
			write_reg(REG_IV_HIGH, (p == 1) ? '1 : (p == 2) ? 64'h0 : {$urandom, $urandom});
			write_reg(REG_IV_LOW, (p == 1) ? '1 : (p == 2) ? 64'h0 : {$urandom, $urandom});
			cfg_we <= 1'b0;

			// Directed corners: zero and all-ones blocks, chain restart mid-run.
			if (p < 12) begin
				send_block(64'h0, 64'h0, 1'b1);
				send_block('1, '1, 1'b0);
			end
			// Mostly chained runs with random content; now and then restart.
			for (int i = 0; i < RAND_BLOCKS; i++) begin
				sc = (i == 0) || ($urandom_range(0, 9) == 0);
				send_block({$urandom, $urandom}, {$urandom, $urandom}, sc);
			end
			drain();

			// Retune the mode and IV alone so the cached round keys get reused.
			if (p % 4 == 3) begin
				write_reg(REG_CIPHER_MODE, 64'($urandom_range(0, 3)));
				write_reg(REG_IV_HIGH, {$urandom, $urandom});
				cfg_we <= 1'b0;
				for (int i = 0; i < 6; i++)
					send_block({$urandom, $urandom}, {$urandom, $urandom}, i == 0);
				drain();
			end
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d blocks (%0d chain restarts) over %0d key/mode settings",
			sent_blocks, chain_starts, NUM_PHASES);
		$display("mismatches counted: %0d", fail_count);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
